FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ANY(label, clk, prop)
`endif

`endif

FILE: rtl/ntpc_pkg.sv
// ----------------------------------------------------------------------------
// ntpc_pkg
// Shared types, constants and tables of the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
package ntpc_pkg;

  localparam logic [10:0] FIRST_YEAR     = 11'd1900;
  localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN   = 32'd60;
  localparam logic [31:0] SECS_COMMON_YR = 32'd365 * SECS_PER_DAY;
  localparam logic [31:0] SECS_LEAP_YR   = 32'd366 * SECS_PER_DAY;
  localparam logic [5:0]  FIRST_DOW      = 6'd1;
  localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

  // Reciprocals for the constant divisions. A day is 128 * 675 seconds, an
  // hour 16 * 225 and a minute 4 * 15; the remainder is shifted by the power
  // of two first, then multiplied and shifted right by 28, 21 and 14 bits.
  localparam logic [18:0] DAY_RECIP  = 19'd397683;
  localparam logic [18:0] HOUR_RECIP = 19'd9321;
  localparam logic [18:0] MIN_RECIP  = 19'd1093;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YEAR,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_MINIT,
    ST_MONTH,
    ST_DOW,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_YEAR,
    OP_DIV_DAY,
    OP_DIV_HOUR,
    OP_DIV_MIN,
    OP_MINIT,
    OP_MONTH,
    OP_DOW,
    OP_CAPTURE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       first;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic dow_done;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd1:                                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:                 len = 5'd30;
      default:                                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/ntpc_ctrl.sv
// ----------------------------------------------------------------------------
// ntpc_ctrl
// Sequencer of the converter: walks years, the constant divisions,
// the month walk and the weekday reduction, and owns both handshakes.
// ----------------------------------------------------------------------------
module ntpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ntpc_pkg::status_t status,
  output ntpc_pkg::cmd_t    cmd
);
  import ntpc_pkg::*;

  state_t     state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Each split first forms the quotient, then takes the remainder.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    cmd.first     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_YEAR;
        end
      end
      ST_YEAR: begin
        cmd.op = OP_YEAR;
        if (status.year_done) begin
          state_nxt = ST_DAY;
          phase_nxt = 1'b0;
        end
      end
      ST_DAY: begin
        cmd.op    = OP_DIV_DAY;
        cmd.first = !phase_r;
        phase_nxt = !phase_r;
        if (phase_r) begin
          state_nxt = ST_HOUR;
        end
      end
      ST_HOUR: begin
        cmd.op    = OP_DIV_HOUR;
        cmd.first = !phase_r;
        phase_nxt = !phase_r;
        if (phase_r) begin
          state_nxt = ST_MIN;
        end
      end
      ST_MIN: begin
        cmd.op    = OP_DIV_MIN;
        cmd.first = !phase_r;
        phase_nxt = !phase_r;
        if (phase_r) begin
          state_nxt = ST_MINIT;
        end
      end
      ST_MINIT: begin
        cmd.op    = OP_MINIT;
        state_nxt = ST_MONTH;
      end
      ST_MONTH: begin
        cmd.op = OP_MONTH;
        if (status.month_done) begin
          state_nxt = ST_DOW;
        end
      end
      ST_DOW: begin
        cmd.op = OP_DOW;
        if (status.dow_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_CAPTURE;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/ntpc_dp.sv
// ----------------------------------------------------------------------------
// ntpc_dp
// Datapath of the converter: year subtractor with leap counters, a shared
// reciprocal-multiply divider, the month walker, weekday accumulator and the
// output register.
// ----------------------------------------------------------------------------
module ntpc_dp (
  input  logic              clk,
  input  ntpc_pkg::cmd_t    cmd,
  output ntpc_pkg::status_t status,
  input  logic [31:0]       in_epoch_seconds,
  output logic [10:0]       out_year,
  output logic [8:0]        out_day_of_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day_of_month,
  output logic [2:0]        out_day_of_week,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute,
  output logic [5:0]        out_second_of_minute
);
  import ntpc_pkg::*;

  logic [31:0] rem_r, rem_nxt;
  logic [10:0] year_r, year_nxt;
  logic [1:0]  y4_r, y4_nxt;
  logic [6:0]  y100_r, y100_nxt;
  logic [8:0]  y400_r, y400_nxt;
  logic [5:0]  dow_r, dow_nxt;
  logic [8:0]  q_r, q_nxt;
  logic [8:0]  yday_r, yday_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [8:0]  dleft_r, dleft_nxt;
  logic [3:0]  month_r, month_nxt;

  logic [10:0] o_year_r;
  logic [8:0]  o_yday_r;
  logic [3:0]  o_month_r;
  logic [4:0]  o_mday_r;
  logic [2:0]  o_dow_r;
  logic [4:0]  o_hour_r;
  logic [5:0]  o_min_r;
  logic [5:0]  o_sec_r;

  logic        leap;
  logic [31:0] ylen;
  logic [31:0] div_base;
  logic [17:0] mul_a;
  logic [18:0] mul_b;
  logic [36:0] mul_p;
  logic [8:0]  quot;
  logic [31:0] div_prod;
  logic [4:0]  mlen;
  logic [5:0]  dow_yr_sum;
  logic [5:0]  dow_mo_sum;

  // Year 1900 sits at 0 mod 4, 0 mod 100 and 300 mod 400.
  assign leap = (y4_r == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen = leap ? SECS_LEAP_YR : SECS_COMMON_YR;

  // The remainder entering a split is below a leap year, a day or an hour,
  // and over those ranges the reciprocals give the exact quotient.
  always_comb begin
    unique case (cmd.op)
      OP_DIV_HOUR: begin
        div_base = SECS_PER_HOUR;
        mul_a    = {5'd0, rem_r[16:4]};
        mul_b    = HOUR_RECIP;
      end
      OP_DIV_MIN: begin
        div_base = SECS_PER_MIN;
        mul_a    = {8'd0, rem_r[11:2]};
        mul_b    = MIN_RECIP;
      end
      default: begin
        div_base = SECS_PER_DAY;
        mul_a    = rem_r[24:7];
        mul_b    = DAY_RECIP;
      end
    endcase
  end

  assign mul_p = {19'd0, mul_a} * {18'd0, mul_b};

  always_comb begin
    unique case (cmd.op)
      OP_DIV_HOUR: quot = {4'd0, mul_p[25:21]};
      OP_DIV_MIN:  quot = {3'd0, mul_p[19:14]};
      default:     quot = mul_p[36:28];
    endcase
  end

  assign div_prod = {23'd0, q_r} * div_base;
  assign mlen     = month_len(month_r, leap);

  assign dow_yr_sum = dow_r + (leap ? 6'd2 : 6'd1);
  assign dow_mo_sum = dow_r + {1'b0, mlen - 5'd28};

  assign status.year_done  = (rem_r < ylen);
  assign status.month_done = (month_r == LAST_MONTH_IDX) || (dleft_r < {4'b0, mlen});
  assign status.dow_done   = (dow_r < 6'd7);

  always_comb begin
    rem_nxt    = rem_r;
    year_nxt   = year_r;
    y4_nxt     = y4_r;
    y100_nxt   = y100_r;
    y400_nxt   = y400_r;
    dow_nxt    = dow_r;
    q_nxt      = q_r;
    yday_nxt   = yday_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    dleft_nxt  = dleft_r;
    month_nxt  = month_r;
    unique case (cmd.op)
      OP_LOAD: begin
        rem_nxt  = in_epoch_seconds;
        year_nxt = FIRST_YEAR;
        y4_nxt   = 2'd0;
        y100_nxt = 7'd0;
        y400_nxt = 9'd300;
        dow_nxt  = FIRST_DOW;
      end
      OP_YEAR: begin
        if (!status.year_done) begin
          rem_nxt  = rem_r - ylen;
          year_nxt = year_r + 11'd1;
          y4_nxt   = y4_r + 2'd1;
          y100_nxt = (y100_r == 7'd99) ? 7'd0 : y100_r + 7'd1;
          y400_nxt = (y400_r == 9'd399) ? 9'd0 : y400_r + 9'd1;
          dow_nxt  = (dow_yr_sum >= 6'd7) ? dow_yr_sum - 6'd7 : dow_yr_sum;
        end
      end
      OP_DIV_DAY, OP_DIV_HOUR, OP_DIV_MIN: begin
        // A new division hands the finished quotient of the previous one on.
        if (cmd.first && cmd.op == OP_DIV_HOUR) begin
          yday_nxt = q_r;
        end
        if (cmd.first && cmd.op == OP_DIV_MIN) begin
          hour_nxt = q_r[4:0];
        end
        if (cmd.first) begin
          q_nxt = quot;
        end else begin
          rem_nxt = rem_r - div_prod;
        end
      end
      OP_MINIT: begin
        minute_nxt = q_r[5:0];
        dleft_nxt  = yday_r;
        month_nxt  = 4'd0;
      end
      OP_MONTH: begin
        if (!status.month_done) begin
          dleft_nxt = dleft_r - {4'b0, mlen};
          month_nxt = month_r + 4'd1;
          dow_nxt   = (dow_mo_sum >= 6'd7) ? dow_mo_sum - 6'd7 : dow_mo_sum;
        end else begin
          dow_nxt = dow_r + {1'b0, dleft_r[4:0]};
        end
      end
      OP_DOW: begin
        if (!status.dow_done) begin
          dow_nxt = dow_r - 6'd7;
        end
      end
      OP_NONE, OP_CAPTURE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    year_r   <= year_nxt;
    y4_r     <= y4_nxt;
    y100_r   <= y100_nxt;
    y400_r   <= y400_nxt;
    dow_r    <= dow_nxt;
    q_r      <= q_nxt;
    yday_r   <= yday_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    dleft_r  <= dleft_nxt;
    month_r  <= month_nxt;
    if (cmd.op == OP_CAPTURE) begin
      o_year_r  <= year_r;
      o_yday_r  <= yday_r + 9'd1;
      o_month_r <= month_r + 4'd1;
      o_mday_r  <= dleft_r[4:0] + 5'd1;
      o_dow_r   <= dow_r[2:0];
      o_hour_r  <= hour_r;
      o_min_r   <= minute_r;
      o_sec_r   <= rem_r[5:0];
    end
  end

  assign out_year             = o_year_r;
  assign out_day_of_year      = o_yday_r;
  assign out_month            = o_month_r;
  assign out_day_of_month     = o_mday_r;
  assign out_day_of_week      = o_dow_r;
  assign out_hour             = o_hour_r;
  assign out_minute           = o_min_r;
  assign out_second_of_minute = o_sec_r;

endmodule

FILE: rtl/ntp_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar
// Converts a 32-bit count of seconds since 1900-01-01 into Gregorian date,
// weekday and time of day.
// ----------------------------------------------------------------------------
// Usage: present a seconds count on in_epoch_seconds with in_valid high; the
// beat is taken on a clock edge where in_stall is low. The block then holds
// in_stall high while it works on that one beat.
// Steps: the year loop takes off whole years since 1900 (0 to 136) and
// finds the final year; reciprocal-multiply splits give day of year, hour
// and minute (quotient first, then remainder); a setup step prepares the
// month walk over up to 12 months; a weekday reduction and a capture into
// the output register follow. The year loop sets most of the run time.
// Throughput is one conversion at a time: the next input beat can be taken
// in the cycle after the result is registered, since the year subtractor and
// the divider serve one beat at a time.
// Results leave through an output register. While the receiver holds
// out_stall, the result stays stable on the out_ ports, and a new input beat
// is still taken; the next result waits in the datapath until the output
// register is free.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; datapath contents are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntp_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_year,
  output logic [8:0]  out_day_of_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [2:0]  out_day_of_week,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second_of_minute
);
  import ntpc_pkg::*;

  // Commands flow from the sequencer to the datapath, status flows back.
  cmd_t    cmd;
  status_t status;

  // Range checks of the delivered fields.
  logic    month_dow_ok;
  logic    time_ok;

  ntpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ntpc_dp u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .status               (status),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_year             (out_year),
    .out_day_of_year      (out_day_of_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month),
    .out_day_of_week      (out_day_of_week),
    .out_hour             (out_hour),
    .out_minute           (out_minute),
    .out_second_of_minute (out_second_of_minute)
  );

  assign month_dow_ok = (out_month >= 4'd1) && (out_month <= 4'd12) &&
                        (out_day_of_week != 3'd7);
  assign time_ok      = (out_hour < 5'd24) && (out_minute < 6'd60) &&
                        (out_second_of_minute < 6'd60);

  // An accepted beat makes the block busy in the next cycle.
  `ASSERT_RST(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
  // A delivered result always carries a legal month and weekday.
  `ASSERT_RST(a_month_dow_legal, clk, rst_n, out_valid |-> month_dow_ok)
  // A delivered result always carries a legal time of day.
  `ASSERT_RST(a_time_legal, clk, rst_n, out_valid |-> time_ok)
  // During reset no result is offered in the following cycle.
  `ASSERT_ANY(a_reset_clears, clk, (!rst_n) |=> !out_valid)

endmodule

FILE: tb/ntp_seconds_to_calendar_tb.sv
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar_tb
// Self-checking bench for the seconds-to-calendar converter. Every input beat
// is predicted into a full calendar record. Each result beat is compared
// field by field against the oldest open prediction. Random gaps are applied
// on the input channel and random stalls on the output channel.
// ----------------------------------------------------------------------------
module ntp_seconds_to_calendar_tb;
  import ntpc_pkg::*;

  // One result beat. The field order matches the order of the out_ ports, so
  // a concatenation of those ports converts directly into this record.
  typedef struct packed {
    logic [10:0] year;
    logic [8:0]  day_of_year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  day_of_week;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
  } calendar_t;

  // The calendar ledger predicts each conversion when its input beat is
  // taken, then matches result beats against those predictions in order.
  class calendar_ledger;
    // Month lengths, January at index 0. February is patched in leap years.
    localparam logic [11:0][4:0] MONTH_DAYS = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                               5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};
    localparam logic [4:0] LEAP_FEB_DAYS = 5'd29;

    calendar_t   awaited_dates[$];
    logic [31:0] awaited_seconds[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    static function bit is_leap_yr(int unsigned yr);
      if (yr % 4 != 0) return 1'b0;
      if (yr % 100 != 0) return 1'b1;
      return yr % 400 == 0;
    endfunction

    static function calendar_t to_calendar(logic [31:0] secs);
      calendar_t   r;
      logic [31:0] left;
      logic [31:0] span;
      int unsigned yr;
      int unsigned yday;
      int unsigned days_left;
      int unsigned mon;
      logic [4:0]  mlen;
      bit          leap;
      left = secs;
      yr = 32'(FIRST_YEAR);
      // Peel whole years off; a remainder of exactly one year is taken too.
      forever begin
        span = is_leap_yr(yr) ? SECS_LEAP_YR : SECS_COMMON_YR;
        if (left < span) break;
        left -= span;
        yr++;
      end
      leap = is_leap_yr(yr);
      yday = left / SECS_PER_DAY;
      left = left % SECS_PER_DAY;
      r.hour = 5'(left / SECS_PER_HOUR);
      left = left % SECS_PER_HOUR;
      r.minute = 6'(left / SECS_PER_MIN);
      r.sec = 6'(left % SECS_PER_MIN);
      days_left = yday;
      mon = 0;
      for (int i = 0; i < 11; i++) begin
        mlen = (i == 1 && leap) ? LEAP_FEB_DAYS : MONTH_DAYS[i];
        if (days_left < mlen) break;
        days_left -= mlen;
        mon++;
      end
      r.year = 11'(yr);
      r.day_of_year = 9'(yday + 1);
      r.month = 4'(mon + 1);
      r.day_of_month = 5'(days_left + 1);
      // Weekdays count from 1900-01-01, a Monday.
      r.day_of_week = 3'((secs / SECS_PER_DAY + FIRST_DOW) % 7);
      return r;
    endfunction

    function int unsigned pending();
      return awaited_dates.size();
    endfunction

    function void note_seconds(logic [31:0] secs);
      awaited_dates.push_back(to_calendar(secs));
      awaited_seconds.push_back(secs);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatch_count++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want, logic [31:0] secs);
      if (got != want)
        report_mismatch($sformatf("%s: got %0d, expected %0d (seconds %0d)",
                                  name, got, want, secs));
    endtask

    task check_result(calendar_t got);
      calendar_t   want;
      logic [31:0] secs;
      if (awaited_dates.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding (year %0d)", got.year));
        return;
      end
      want = awaited_dates.pop_front();
      secs = awaited_seconds.pop_front();
      compare_field("year", 32'(got.year), 32'(want.year), secs);
      compare_field("day_of_year", 32'(got.day_of_year), 32'(want.day_of_year), secs);
      compare_field("month", 32'(got.month), 32'(want.month), secs);
      compare_field("day_of_month", 32'(got.day_of_month), 32'(want.day_of_month), secs);
      compare_field("day_of_week", 32'(got.day_of_week), 32'(want.day_of_week), secs);
      compare_field("hour", 32'(got.hour), 32'(want.hour), secs);
      compare_field("minute", 32'(got.minute), 32'(want.minute), secs);
      compare_field("second_of_minute", 32'(got.sec), 32'(want.sec), secs);
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_year;
  logic [8:0]  out_day_of_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [2:0]  out_day_of_week;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second_of_minute;

  // While calm is set, neither side idles, so stretches of back-to-back
  // beats are exercised as well.
  bit calm = 1'b0;

  calendar_ledger ledger = new();

  ntp_seconds_to_calendar uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_year             (out_year),
    .out_day_of_year      (out_day_of_year),
    .out_month            (out_month),
    .out_day_of_month     (out_day_of_month),
    .out_day_of_week      (out_day_of_week),
    .out_hour             (out_hour),
    .out_minute           (out_minute),
    .out_second_of_minute (out_second_of_minute)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Seconds count for a given year, zero-based day of year and time of day.
  function automatic logic [31:0] stamp(int unsigned yr, int unsigned yday,
                                        int unsigned hh, int unsigned mm, int unsigned ss);
    int unsigned days;
    days = yday;
    for (int unsigned y = 32'(FIRST_YEAR); y < yr; y++)
      days += calendar_ledger::is_leap_yr(y) ? 366 : 365;
    return days * SECS_PER_DAY + hh * SECS_PER_HOUR + mm * SECS_PER_MIN + ss;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Presents one beat and returns at the edge where it is taken. The caller
  // is always at a clock edge, so in_valid either stays high into the next
  // beat or drops for a gap; it never gets two assignments in one step.
  task automatic send_seconds(logic [31:0] secs);
    int unsigned idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_seconds(secs);
  endtask

  // Result side. Signals are read right at the edge, before any register in
  // the design or this bench updates, so a beat counts exactly when the
  // design sees out_valid high and out_stall low. The stall level is held
  // for a gap drawn by pick_gap, then redrawn.
  initial begin : result_side
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        ledger.check_result({out_year, out_day_of_year, out_month, out_day_of_month,
                             out_day_of_week, out_hour, out_minute, out_second_of_minute});
      if (hold != 0) begin
        hold--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 2) == 0);
        hold = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned yr;
    int unsigned yday;
    int unsigned day_count;
    int          offset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: both ends of the input range, exact year boundaries and
    // the second before them, February in a century year that is not a leap
    // year, February 29 in ordinary and century leap years, the last day of
    // a leap year, a few bit patterns, and one week to walk every weekday.
    send_seconds(32'h0000_0000);
    send_seconds(32'hFFFF_FFFF);
    send_seconds(stamp(1901, 0, 0, 0, 0));
    send_seconds(stamp(1901, 0, 0, 0, 0) - 1);
    send_seconds(stamp(1900, 58, 23, 59, 59));
    send_seconds(stamp(1900, 59, 0, 0, 0));
    send_seconds(stamp(1904, 59, 12, 30, 30));
    send_seconds(stamp(1904, 365, 23, 59, 59));
    send_seconds(stamp(2000, 59, 7, 45, 1));
    send_seconds(stamp(2000, 0, 0, 0, 0) - 1);
    send_seconds(stamp(2000, 0, 0, 0, 0));
    send_seconds(stamp(1970, 0, 0, 0, 0));
    send_seconds(32'h8000_0000);
    send_seconds(32'h7FFF_FFFF);
    send_seconds(32'h5555_5555);
    send_seconds(32'hAAAA_AAAA);
    for (int d = 0; d < 7; d++)
      send_seconds(stamp(2011, 40 + d, d * 3, d * 7, d * 8));

    // Random beats, in chunks that are sometimes run without any idling.
    for (int n = 0; n < 800; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_seconds($urandom);
      end else if (kind < 60) begin
        // Near a year boundary, where the year loop decides.
        yr = $urandom_range(1901, 2036);
        offset = $urandom_range(0, 4) - 2;
        send_seconds(stamp(yr, 0, 0, 0, 0) + offset);
      end else if (kind < 75) begin
        // Near a midnight, where every time-of-day field rolls over.
        day_count = $urandom_range(1, 49709);
        offset = $urandom_range(0, 6) - 3;
        send_seconds(day_count * SECS_PER_DAY + offset);
      end else begin
        // A calendar position drawn field by field, month ends included.
        yr = $urandom_range(1900, 2035);
        yday = $urandom_range(0, calendar_ledger::is_leap_yr(yr) ? 365 : 364);
        send_seconds(stamp(yr, yday, $urandom_range(0, 23), $urandom_range(0, 59),
                           $urandom_range(0, 59)));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then allow one full conversion time for any stray result.
    while (ledger.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (ledger.mismatch_count == 0 && ledger.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
